// File: rtl/core/sic_pkg.sv
package sic_pkg;

    localparam int SIDE_W  = 16;
    localparam int COUNT_W = 32;
    localparam int BIT_W   = $clog2(SIDE_W);
    localparam int unsigned DEFAULT_MAX_SIDE = 65535;

    // one-hot strobes from the controller, one per sequencer step
    typedef struct packed {
        logic load;
        logic sq;
        logic chk;
        logic mul;
        logic cmp;
        logic fmul;
        logic rem;
        logic leg1;
        logic leg2;
        logic leg3;
        logic leg4;
        logic out;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic last_bit;
        logic hit;
    } t_status;

endpackage

// File: rtl/core/sic_datapath.sv
module sic_datapath
    import sic_pkg::*;
#(
    parameter int unsigned MAX_SIDE = DEFAULT_MAX_SIDE
) (
    input  logic               i_clk,
    input  t_cmd               i_cmd,
    input  logic [SIDE_W-1:0]  i_side_len,
    input  logic [COUNT_W-1:0] i_cell_count,
    output t_status            o_status,
    output logic [SIDE_W-1:0]  o_row,
    output logic [SIDE_W-1:0]  o_col,
    output logic               o_oor
);

    localparam logic [SIDE_W-1:0] SideCap =
        (MAX_SIDE > ((32'd1 << SIDE_W) - 32'd1)) ? {SIDE_W{1'b1}} : SIDE_W'(MAX_SIDE);

    logic [SIDE_W-1:0]    r_n;
    logic [COUNT_W-1:0]   r_b;
    logic [SIDE_W-1:0]    r_k;
    logic [BIT_W-1:0]     r_bit;
    logic [2*SIDE_W-1:0]  r_prod;
    logic                 r_bad;
    logic [COUNT_W-1:0]   r_r;
    logic [SIDE_W-1:0]    r_m;
    logic [SIDE_W-1:0]    r_row;
    logic [SIDE_W-1:0]    r_col;
    logic [SIDE_W-1:0]    r_o_row;
    logic [SIDE_W-1:0]    r_o_col;
    logic                 r_o_oor;

    logic [SIDE_W-1:0]    w_cand;
    logic [SIDE_W-1:0]    w_mul_a;
    logic [SIDE_W-1:0]    w_mul_b;
    logic [2*SIDE_W-1:0]  w_prod;
    logic [2*SIDE_W+1:0]  w_prod4;
    logic                 w_take;
    logic [SIDE_W-1:0]    w_mm1;
    logic [SIDE_W:0]      w_km;
    logic [SIDE_W-1:0]    w_r16;

    assign w_cand  = r_k | (SIDE_W'(1) << r_bit);
    assign w_prod4 = {r_prod, 2'b00};
    assign w_mm1   = r_m - SIDE_W'(1);
    assign w_km    = {1'b0, r_k} + {1'b0, r_m};
    assign w_r16   = r_r[SIDE_W-1:0];

    // single shared 16x16 multiplier
    always_comb begin
        if (i_cmd.sq) begin
            w_mul_a = r_n;
            w_mul_b = r_n;
        end else if (i_cmd.fmul) begin
            w_mul_a = r_k;
            w_mul_b = r_n - r_k;
        end else begin
            w_mul_a = w_cand;
            w_mul_b = r_n - w_cand;
        end
    end

    assign w_prod = (2*SIDE_W)'(w_mul_a) * (2*SIDE_W)'(w_mul_b);

    // cells outside ring cand must not exceed the count, ring must exist
    assign w_take = ({w_cand, 1'b0} < {1'b0, r_n}) &&
                    (w_prod4 <= {2'b00, r_b});

    always_comb begin
        o_status.bad      = (r_b == '0) || (r_b > r_prod);
        o_status.last_bit = (r_bit == '0);
        if (i_cmd.leg1) begin
            o_status.hit = (r_r <= COUNT_W'(r_m));
        end else if (i_cmd.leg2 || i_cmd.leg3) begin
            o_status.hit = (r_r <= COUNT_W'(w_mm1));
        end else begin
            o_status.hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= (i_side_len > SideCap) ? SideCap : i_side_len;
            r_b <= i_cell_count;
        end
        if (i_cmd.sq || i_cmd.mul || i_cmd.fmul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.chk) begin
            r_bad <= o_status.bad;
            r_k   <= '0;
            r_bit <= BIT_W'(SIDE_W - 1);
            r_row <= '0;
            r_col <= '0;
        end
        if (i_cmd.cmp) begin
            if (w_take) begin
                r_k <= w_cand;
            end
            r_bit <= r_bit - BIT_W'(1);
        end
        if (i_cmd.rem) begin
            r_r <= r_b - w_prod4[COUNT_W-1:0];
            r_m <= r_n - {r_k[SIDE_W-2:0], 1'b0};
        end
        if (i_cmd.leg1) begin
            if (o_status.hit) begin
                r_row <= r_k + SIDE_W'(1);
                r_col <= r_k + w_r16;
            end else begin
                r_r   <= r_r - COUNT_W'(r_m);
                r_col <= w_km[SIDE_W-1:0];
            end
        end
        if (i_cmd.leg2) begin
            if (o_status.hit) begin
                r_row <= r_k + SIDE_W'(1) + w_r16;
            end else begin
                r_r   <= r_r - COUNT_W'(w_mm1);
                r_row <= w_km[SIDE_W-1:0];
            end
        end
        if (i_cmd.leg3) begin
            if (o_status.hit) begin
                r_col <= w_km[SIDE_W-1:0] - w_r16;
            end else begin
                r_r   <= r_r - COUNT_W'(w_mm1);
                r_col <= r_k + SIDE_W'(1);
            end
        end
        if (i_cmd.leg4) begin
            r_row <= (r_r <= COUNT_W'(w_km)) ? (w_km[SIDE_W-1:0] - w_r16) : '0;
        end
        if (i_cmd.out) begin
            r_o_row <= r_row;
            r_o_col <= r_col;
            r_o_oor <= r_bad;
        end
    end

    assign o_row = r_o_row;
    assign o_col = r_o_col;
    assign o_oor = r_o_oor;

endmodule

// File: rtl/core/sic_ctrl.sv
module sic_ctrl
    import sic_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] StIdle = 4'd0;
    localparam logic [3:0] StSq   = 4'd1;
    localparam logic [3:0] StChk  = 4'd2;
    localparam logic [3:0] StMul  = 4'd3;
    localparam logic [3:0] StCmp  = 4'd4;
    localparam logic [3:0] StFmul = 4'd5;
    localparam logic [3:0] StRem  = 4'd6;
    localparam logic [3:0] StLeg1 = 4'd7;
    localparam logic [3:0] StLeg2 = 4'd8;
    localparam logic [3:0] StLeg3 = 4'd9;
    localparam logic [3:0] StLeg4 = 4'd10;
    localparam logic [3:0] StDone = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        o_in_ready  = 1'b0;
        case (r_state)
            StIdle: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = StSq;
                end
            end
            StSq: begin
                o_cmd.sq = 1'b1;
                n_state  = StChk;
            end
            StChk: begin
                o_cmd.chk = 1'b1;
                n_state   = i_status.bad ? StDone : StMul;
            end
            StMul: begin
                o_cmd.mul = 1'b1;
                n_state   = StCmp;
            end
            StCmp: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_status.last_bit ? StFmul : StMul;
            end
            StFmul: begin
                o_cmd.fmul = 1'b1;
                n_state    = StRem;
            end
            StRem: begin
                o_cmd.rem = 1'b1;
                n_state   = StLeg1;
            end
            StLeg1: begin
                o_cmd.leg1 = 1'b1;
                n_state    = i_status.hit ? StDone : StLeg2;
            end
            StLeg2: begin
                o_cmd.leg2 = 1'b1;
                n_state    = i_status.hit ? StDone : StLeg3;
            end
            StLeg3: begin
                o_cmd.leg3 = 1'b1;
                n_state    = i_status.hit ? StDone : StLeg4;
            end
            StLeg4: begin
                o_cmd.leg4 = 1'b1;
                n_state    = StDone;
            end
            StDone: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out = 1'b1;
                    n_state   = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/spiral_index_to_coordinate_core.sv
// Spiral index to coordinate. For a one-based position along a clockwise
// spiral that starts at the top-left cell of an n x n grid and winds inward,
// the block returns the one-based row and column. The side n is written on
// the cfg channel (reset value 1) and is capped at MAX_SIDE; change it only
// while no word is in flight. A position of zero or above n*n returns
// row = col = 0 with the out-of-range flag set. One word is worked at a
// time: accept, then n*n and the range check, then the ring search, a
// 16-step successive approximation where each step is a product on the
// shared 16x16 multiplier followed by a compare, then the ring remainder
// and one to four steps walking the ring's legs, then the result is moved
// to the output register. The next word is taken the cycle after the
// result is loaded, while the previous result may still be waiting on
// m_tready.
module spiral_index_to_coordinate_core
    import sic_pkg::*;
#(
    parameter int unsigned MAX_SIDE = DEFAULT_MAX_SIDE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config: side length
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SIDE_W-1:0]  i_cfg_data,     // [15:0] side_len
    // input word
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [COUNT_W-1:0] s_tdata,        // [31:0] cell_count
    // result word
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,        // [15:0] row, [31:16] col
    output logic               m_tuser         // [0] out_of_range
);

    logic [SIDE_W-1:0] r_side_len;
    t_cmd              w_cmd;
    t_status           w_status;
    logic [SIDE_W-1:0] w_row;
    logic [SIDE_W-1:0] w_col;
    logic              w_oor;

    // config register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_len <= SIDE_W'(1);
        end else if (i_cfg_valid) begin
            r_side_len <= i_cfg_data;
        end
    end

    sic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    sic_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_side_len   (r_side_len),
        .i_cell_count (s_tdata),
        .o_status     (w_status),
        .o_row        (w_row),
        .o_col        (w_col),
        .o_oor        (w_oor)
    );

    assign m_tdata = {w_col, w_row};
    assign m_tuser = w_oor;

    // one word at a time: no second accept right after an accept
    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word is in work");

    // an out-of-range result carries a zero coordinate
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 32'd0))
        else $error("out-of-range result with nonzero coordinate");

    // an in-range result always lands on a real cell
    a_inrange_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser) |-> ((m_tdata[15:0] != 16'd0) && (m_tdata[31:16] != 16'd0)))
        else $error("in-range result with zero row or column");

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule
